// ===== rtl/ksdf_pkg.sv =====
// Package for the keyboard scan-code decoder: payload structs, codes and
// the German-layout scan-code set 1 character tables.
// No dependencies.
`default_nettype none

package ksdf_pkg;

  localparam int unsigned RingDepthDefault = 256;

  // Command codes on the input channel
  localparam logic CmdScan = 1'b0;
  localparam logic CmdRead = 1'b1;

  localparam logic [7:0] PrefixCode = 8'hE0;
  localparam logic [7:0] ReleaseBit = 8'b1000_0000;
  localparam logic [7:0] KeyMask    = 8'b0111_1111;
  localparam logic [6:0] LshiftKey  = 7'h2A;

  typedef struct packed {
    logic       cmd;
    logic [7:0] scan_code;
  } ksdf_in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       chars_waiting;
  } ksdf_out_t;

  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (key)
      7'h1E: ch = 8'h61;  7'h30: ch = 8'h62;  7'h2E: ch = 8'h63;
      7'h20: ch = 8'h64;  7'h12: ch = 8'h65;  7'h21: ch = 8'h66;
      7'h22: ch = 8'h67;  7'h23: ch = 8'h68;  7'h17: ch = 8'h69;
      7'h24: ch = 8'h6A;  7'h25: ch = 8'h6B;  7'h26: ch = 8'h6C;
      7'h32: ch = 8'h6D;  7'h31: ch = 8'h6E;  7'h18: ch = 8'h6F;
      7'h19: ch = 8'h70;  7'h10: ch = 8'h71;  7'h13: ch = 8'h72;
      7'h1F: ch = 8'h73;  7'h14: ch = 8'h74;  7'h16: ch = 8'h75;
      7'h2F: ch = 8'h76;  7'h11: ch = 8'h77;  7'h2D: ch = 8'h78;
      7'h2C: ch = 8'h79;  7'h15: ch = 8'h7A;
      7'h02: ch = 8'h31;  7'h03: ch = 8'h32;  7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;  7'h06: ch = 8'h35;  7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;  7'h09: ch = 8'h38;  7'h0A: ch = 8'h39;
      7'h0B: ch = 8'h30;
      7'h39: ch = 8'h20;  7'h0F: ch = 8'h09;  7'h1C: ch = 8'h0D;
      7'h33: ch = 8'h2C;  7'h34: ch = 8'h2E;  7'h35: ch = 8'h2D;
      7'h2B: ch = 8'h23;  7'h56: ch = 8'h3C;  7'h29: ch = 8'h5E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (key)
      7'h1E: ch = 8'h41;  7'h30: ch = 8'h42;  7'h2E: ch = 8'h43;
      7'h20: ch = 8'h44;  7'h12: ch = 8'h45;  7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;  7'h23: ch = 8'h48;  7'h17: ch = 8'h49;
      7'h24: ch = 8'h4A;  7'h25: ch = 8'h4B;  7'h26: ch = 8'h4C;
      7'h32: ch = 8'h4D;  7'h31: ch = 8'h4E;  7'h18: ch = 8'h4F;
      7'h19: ch = 8'h50;  7'h10: ch = 8'h51;  7'h13: ch = 8'h52;
      7'h1F: ch = 8'h53;  7'h14: ch = 8'h54;  7'h16: ch = 8'h55;
      7'h2F: ch = 8'h56;  7'h11: ch = 8'h57;  7'h2D: ch = 8'h58;
      7'h2C: ch = 8'h59;  7'h15: ch = 8'h5A;
      7'h02: ch = 8'h21;  7'h03: ch = 8'h22;  7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;  7'h07: ch = 8'h26;  7'h08: ch = 8'h2F;
      7'h09: ch = 8'h28;  7'h0A: ch = 8'h29;  7'h0B: ch = 8'h3D;
      7'h39: ch = 8'h20;  7'h0F: ch = 8'h09;  7'h1C: ch = 8'h0D;
      7'h33: ch = 8'h3B;  7'h34: ch = 8'h3A;  7'h35: ch = 8'h5F;
      7'h2B: ch = 8'h27;  7'h56: ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/keyboard_scancode_decoder_fifo.sv =====
// Keyboard scan-code decoder with a character ring buffer.
// Depends on ksdf_pkg (payload structs, codes, character tables).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries either a
//   scan-code set 1 byte (cmd = CmdScan) or a read request (cmd = CmdRead).
//   Every input transfer produces exactly one output transfer on
//   (out_valid_o / out_stall_i / out_data_o), in order.
//   A press byte is looked up in the German-layout tables (shifted when left
//   shift is held and the shifted entry is nonzero) and pushed into the ring;
//   a full ring drops its oldest character. A left-shift release byte clears
//   the shift mark; the prefix byte 0xE0 is ignored. A read pops the oldest
//   character, or returns 0 on an empty ring.
//
// Throughput and datapath:
//   One item per cycle sustained while the output is not stalled. A result
//   passes the synchronous ring read in the read stage, then the
//   two-entry output buffer. Pointer update is done at accept time, so
//   back-to-back pushes and pops need no interlock.
// Reset: pointers, shift mark and all valid state clear; the ring RAM is not
//   cleared (only written entries are ever read). No clearing pass.
// Stall: a stalled output fills the two-entry buffer, then holds the read
//   stage, then stalls the input; nothing is lost or repeated.
`default_nettype none

module keyboard_scancode_decoder_fifo
  import ksdf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ksdf_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ksdf_out_t      out_data_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // ring storage and pointers
  logic [7:0]      ring_mem [RING_DEPTH];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic            lshift_q, lshift_d;   // only pressed mark that is ever read

  // read stage (one item waiting on RAM data)
  logic       s1_valid_q, s1_valid_d;
  logic       s1_hit_q;                  // read transfer that popped a character
  logic       s1_waiting_q;
  logic [7:0] rdata_q;

  // two-entry output buffer
  ksdf_out_t  obuf_q [2];
  logic       obuf_wr_q, obuf_rd_q;
  logic [1:0] obuf_cnt_q, obuf_cnt_d;

  logic       in_acc, s1_move, out_pop;
  logic       is_read, is_prefix, is_release, is_press, ring_nonempty, pop;
  logic [6:0] key;
  logic [7:0] plain_ch, shift_ch, push_ch;
  logic [PtrW-1:0] head_inc;
  ksdf_out_t  s1_result;

  assign out_pop    = out_valid_o && !out_stall_i;
  assign s1_move    = s1_valid_q && (obuf_cnt_q != 2'd2);
  assign in_stall_o = s1_valid_q && (obuf_cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --- decode and pointer update at accept ---
  always_comb begin
    is_read       = (in_data_i.cmd == CmdRead);
    is_prefix     = (in_data_i.scan_code == PrefixCode);
    is_release    = !is_read && !is_prefix && ((in_data_i.scan_code & ReleaseBit) != 8'h00);
    is_press      = !is_read && !is_prefix && ((in_data_i.scan_code & ReleaseBit) == 8'h00);
    key           = in_data_i.scan_code[6:0] & KeyMask[6:0];
    ring_nonempty = (head_q != tail_q);
    pop           = is_read && ring_nonempty;

    lshift_d = lshift_q;
    if (in_acc && key == LshiftKey) begin
      if (is_press) begin
        lshift_d = 1'b1;
      end else if (is_release) begin
        lshift_d = 1'b0;
      end
    end

    plain_ch = plain_char(key);
    shift_ch = shift_char(key);
    push_ch  = (lshift_d && shift_ch != 8'h00) ? shift_ch : plain_ch;

    head_inc = ptr_next(head_q);
    head_d   = head_q;
    tail_d   = tail_q;
    if (in_acc) begin
      if (pop) begin
        tail_d = ptr_next(tail_q);
      end else if (is_press) begin
        head_d = head_inc;
        // full ring: drop oldest
        if (head_inc == tail_q) begin
          tail_d = ptr_next(tail_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      lshift_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      lshift_q <= lshift_d;
    end
  end

  // ring RAM: one write port at head, one registered read port at tail
  always_ff @(posedge clk_i) begin
    if (in_acc && is_press) begin
      ring_mem[head_q] <= push_ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= ring_mem[tail_q];
    end
  end

  // --- read stage ---
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_hit_q     <= pop;
      s1_waiting_q <= (head_d != tail_d);
    end
  end

  always_comb begin
    s1_result.read_char     = s1_hit_q ? rdata_q : 8'h00;
    s1_result.chars_waiting = s1_waiting_q;
  end

  // --- output buffer ---
  always_comb begin
    obuf_cnt_d = obuf_cnt_q;
    if (s1_move && !out_pop) begin
      obuf_cnt_d = obuf_cnt_q + 2'd1;
    end else if (!s1_move && out_pop) begin
      obuf_cnt_d = obuf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_cnt_q <= 2'd0;
      obuf_wr_q  <= 1'b0;
      obuf_rd_q  <= 1'b0;
    end else begin
      obuf_cnt_q <= obuf_cnt_d;
      if (s1_move) begin
        obuf_wr_q <= !obuf_wr_q;
      end
      if (out_pop) begin
        obuf_rd_q <= !obuf_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      obuf_q[obuf_wr_q] <= s1_result;
    end
  end

  assign out_valid_o = (obuf_cnt_q != 2'd0);
  assign out_data_o  = obuf_q[obuf_rd_q];

endmodule

`default_nettype wire

// ===== tb/ksdf_checker.sv =====
// Checker for keyboard_scancode_decoder_fifo: watches both channels, keeps its own
// key map, character tables and ring, and compares every output transfer.
// Depends on ksdf_pkg for the payload structs and codes.
module ksdf_checker
  import ksdf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire ksdf_in_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire ksdf_out_t out_data_i,
  output int             mismatches_o,
  output int             outstanding_o
);

  localparam int Depth = RingDepthDefault;

  logic [7:0]   plain_tbl [128];
  logic [7:0]   shift_tbl [128];
  logic [6:0]   letter_key [26];
  logic [7:0]   digit_shift [10];
  logic [127:0] key_down;
  logic [7:0]   char_ring [Depth];
  int           wr_idx;
  int           rd_idx;
  ksdf_out_t    decoded_q [$];
  int           mismatches = 0;
  int           results_seen = 0;

  assign mismatches_o = mismatches;

  // German layout, scan-code set 1
  initial begin
    letter_key = '{7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17,
                   7'h24, 7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13,
                   7'h1F, 7'h14, 7'h16, 7'h2F, 7'h11, 7'h2D, 7'h2C, 7'h15};
    digit_shift = '{"!", 8'h22, 8'h00, "$", "%", "&", "/", "(", ")", "="};
    for (int i = 0; i < 128; i++) begin
      plain_tbl[i] = 8'h00;
      shift_tbl[i] = 8'h00;
    end
    for (int i = 0; i < 26; i++) begin
      plain_tbl[letter_key[i]] = 8'h61 + 8'(i);
      shift_tbl[letter_key[i]] = 8'h41 + 8'(i);
    end
    for (int i = 0; i < 10; i++) begin
      plain_tbl[2 + i] = (i == 9) ? "0" : 8'h31 + 8'(i);
      shift_tbl[2 + i] = digit_shift[i];
    end
    plain_tbl[7'h39] = " ";   shift_tbl[7'h39] = " ";
    plain_tbl[7'h0F] = 8'h09; shift_tbl[7'h0F] = 8'h09;
    plain_tbl[7'h1C] = 8'h0D; shift_tbl[7'h1C] = 8'h0D;
    plain_tbl[7'h33] = ",";   shift_tbl[7'h33] = ";";
    plain_tbl[7'h34] = ".";   shift_tbl[7'h34] = ":";
    plain_tbl[7'h35] = "-";   shift_tbl[7'h35] = "_";
    plain_tbl[7'h2B] = "#";   shift_tbl[7'h2B] = 8'h27;
    plain_tbl[7'h56] = "<";   shift_tbl[7'h56] = ">";
    plain_tbl[7'h29] = "^";
  end

  // Applies one input transfer to the local state, returns the expected output.
  function automatic ksdf_out_t apply_transfer(input ksdf_in_t item);
    ksdf_out_t  res;
    logic [6:0] key;
    logic [7:0] ch;
    res.read_char = 8'h00;
    key = item.scan_code[6:0];
    if (item.cmd == CmdRead) begin
      if (rd_idx != wr_idx) begin
        res.read_char = char_ring[rd_idx];
        rd_idx = (rd_idx + 1) % Depth;
      end
    end else if (item.scan_code != PrefixCode) begin
      if ((item.scan_code & ReleaseBit) != 8'h00) begin
        key_down[key] = 1'b0;
      end else begin
        key_down[key] = 1'b1;
        if (key_down[LshiftKey] && shift_tbl[key] != 8'h00) ch = shift_tbl[key];
        else ch = plain_tbl[key];
        char_ring[wr_idx] = ch;
        wr_idx = (wr_idx + 1) % Depth;
        // full ring: oldest character is dropped
        if (wr_idx == rd_idx) rd_idx = (rd_idx + 1) % Depth;
      end
    end
    res.chars_waiting = (rd_idx != wr_idx);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t, result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ksdf_out_t want;
    if (!rst_ni) begin
      key_down = '0;
      wr_idx = 0;
      rd_idx = 0;
      decoded_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("output transfer %h with none pending", out_data_i));
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.read_char !== want.read_char)
            report_mismatch($sformatf("read_char %h, predicted %h",
                                      out_data_i.read_char, want.read_char));
          if (out_data_i.chars_waiting !== want.chars_waiting)
            report_mismatch($sformatf("chars_waiting %b, predicted %b",
                                      out_data_i.chars_waiting, want.chars_waiting));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) decoded_q.push_back(apply_transfer(in_data_i));
      outstanding_o <= decoded_q.size();
    end
  end

endmodule

// ===== tb/keyboard_scancode_decoder_fifo_tb.sv =====
// Testbench top for keyboard_scancode_decoder_fifo: makes key press/release
// and read stimulus with random idling and gives the verdict.
// Depends on ksdf_pkg and ksdf_checker, which predicts and compares.
module keyboard_scancode_decoder_fifo_tb;
  import ksdf_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ksdf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ksdf_out_t out_data;

  int mismatches;
  int outstanding;     // results still owed by the block
  int items_sent = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;  // random gaps and stalls enabled

  // Keys that decode to something, with shifted-zero keys among them
  logic [6:0] typing_keys [20] = '{7'h1E, 7'h30, 7'h15, 7'h2C, 7'h10, 7'h02, 7'h03,
                                   7'h04, 7'h0B, 7'h39, 7'h0F, 7'h1C, 7'h33, 7'h34,
                                   7'h35, 7'h2B, 7'h56, 7'h29, 7'h12, 7'h26};

  always #5 clk = ~clk;

  keyboard_scancode_decoder_fifo dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ksdf_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Receiver back-pressure: random bursts of stalled cycles, none once
  // idling is switched off (a burst already started still runs out).
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One input transfer. An optional idle gap with valid low goes first; valid
  // stays high between back-to-back transfers.
  task automatic send(input logic op, input logic [7:0] code);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: op, scan_code: code};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sender holds off until the block owes nothing more.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly mapped keys, some arbitrary 7-bit codes
  function automatic logic [6:0] pick_key();
    if ($urandom_range(0, 3) != 0) return typing_keys[$urandom_range(0, 19)];
    return 7'($urandom);
  endfunction

  // A well-formed typing sequence: optional shift hold, presses each mostly
  // followed by their release (sometimes behind an extended prefix), then
  // a few reads.
  task automatic typing_burst();
    int         n;
    bit         shifted;
    logic [6:0] key;
    shifted = ($urandom_range(0, 2) == 0);
    n = $urandom_range(1, 5);
    if (shifted) send(CmdScan, {1'b0, LshiftKey});
    repeat (n) begin
      key = pick_key();
      if ($urandom_range(0, 5) == 0) send(CmdScan, PrefixCode);
      send(CmdScan, {1'b0, key});
      if ($urandom_range(0, 3) != 0) send(CmdScan, {1'b1, key});
    end
    if (shifted && $urandom_range(0, 4) != 0) send(CmdScan, {1'b1, LshiftKey});
    repeat ($urandom_range(0, n + 1)) send(CmdRead, 8'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, prefix, extremes of the code byte, shift handling
    send(CmdRead, 8'h00);                 // read on an empty ring
    send(CmdScan, PrefixCode);            // ignored
    send(CmdScan, 8'h1E);                 // 'a'
    send(CmdScan, 8'h00);                 // unmapped, 0 is stored
    send(CmdScan, 8'h7F);                 // highest press code, unmapped
    send(CmdScan, 8'hFF);                 // releases, nothing pushed
    send(CmdScan, 8'h80);
    send(CmdScan, {1'b0, LshiftKey});     // shift press itself pushes 0
    send(CmdScan, 8'h1E);                 // 'A'
    send(CmdScan, 8'h04);                 // shifted entry empty -> '3'
    send(CmdScan, 8'h29);                 // shifted entry empty -> '^'
    send(CmdScan, 8'h2B);                 // apostrophe
    send(CmdScan, {1'b1, LshiftKey});     // shift release
    send(CmdScan, 8'h2B);                 // '#'
    repeat (6) begin                      // read past the end, code bits toggled
      send(CmdRead, 8'hFF);
      send(CmdRead, 8'h00);
    end

    // Random typing with noise items mixed in
    while (items_sent < 260) begin
      if ($urandom_range(0, 4) == 0) send(1'($urandom), 8'($urandom));
      else typing_burst();
    end

    wait_drained();

    // Overrun the ring: many presses and no reads
    repeat (300) begin
      if ($urandom_range(0, 9) == 0) send(CmdScan, {1'b1, 7'($urandom)});
      else send(CmdScan, {1'b0, pick_key()});
    end

    // Last part: no idling on either side, read-heavy
    idle_on <= 1'b0;
    while (items_sent < 650) begin
      if ($urandom_range(0, 1) == 0) send(CmdRead, 8'($urandom));
      else typing_burst();
    end

    wait_drained();
    repeat (8) @(posedge clk);   // catch any stray output after the drain
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
